>>> src/ctcp_pkg.sv
// shared types and constants of the console turn command parser
package ctcp_pkg;

    localparam int LINE_DEPTH  = 16;
    localparam int LINE_IW     = $clog2(LINE_DEPTH);
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_IW    = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_FORWARD  = 3'd1;
    localparam logic [2:0] ACT_STOP     = 3'd2;
    localparam logic [2:0] ACT_TURN     = 3'd3;
    localparam logic [2:0] ACT_INVALID  = 3'd4;
    localparam logic [2:0] ACT_TOO_LONG = 3'd5;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UG    = 8'h47;
    localparam logic [7:0] CH_UT    = 8'h54;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LG    = 8'h67;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    typedef enum logic [2:0] {
        CLS_TURN  = 3'd0,
        CLS_STOP  = 3'd1,
        CLS_GO    = 3'd2,
        CLS_ENTER = 3'd3,
        CLS_BS    = 3'd4,
        CLS_OTHER = 3'd5
    } t_class;

    typedef struct packed {
        t_class     cls;
        logic [7:0] data;
    } t_item;

endpackage

>>> src/ctcp_front.sv
// front end: accepts console bytes and classifies them into queue entries
module ctcp_front import ctcp_pkg::*; (
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    t_class cls;

    always_comb begin
        if (i_rx_byte inside {CH_LT, CH_UT}) begin
            cls = CLS_TURN;
        end else if (i_rx_byte inside {CH_LX, CH_UX, CH_SPACE, CH_ESC}) begin
            cls = CLS_STOP;
        end else if (i_rx_byte inside {CH_LG, CH_UG}) begin
            cls = CLS_GO;
        end else if (i_rx_byte inside {CH_CR, CH_LF}) begin
            cls = CLS_ENTER;
        end else if (i_rx_byte inside {CH_BS, CH_DEL}) begin
            cls = CLS_BS;
        end else begin
            cls = CLS_OTHER;
        end
    end

    assign o_ready     = !i_full;
    assign o_push      = i_valid && !i_full;
    assign o_item.cls  = cls;
    assign o_item.data = i_rx_byte;

endmodule

>>> src/ctcp_queue.sv
// short queue of classified bytes between front and back end
module ctcp_queue import ctcp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_item
);

    t_item               r_entry [QUEUE_DEPTH];
    logic [QUEUE_IW-1:0] r_wr_ptr;
    logic [QUEUE_IW-1:0] r_rd_ptr;
    logic [QUEUE_IW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_IW'(QUEUE_DEPTH - 1)) ? '0
                                                                      : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

    assign o_full  = (r_count == (QUEUE_IW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_entry[r_rd_ptr];

endmodule

>>> src/ctcp_back.sv
// back end: turn mode state, line buffer, number walk and result register
module ctcp_back import ctcp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_action,
    output logic [7:0]  o_command_byte,
    output logic [31:0] o_turn_millideg
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    localparam logic [LINE_IW-1:0] CNT_MAX = LINE_IW'(LINE_DEPTH - 1);
    localparam logic [36:0] MAG_CAP  = 37'h1_0000_0000;
    localparam logic [32:0] NEG_LIM  = 33'h0_8000_0000;
    localparam logic [32:0] POS_LIM  = 33'h0_7FFF_FFFF;

    t_state             r_state, n_state;
    logic               r_mode, n_mode;
    logic [LINE_IW-1:0] r_count, n_count;
    logic [LINE_IW-1:0] r_len, n_len;
    logic [LINE_IW-1:0] r_idx, n_idx;
    logic               r_neg, n_neg;
    logic               r_digit, n_digit;
    logic               r_point, n_point;
    logic [1:0]         r_frac, n_frac;
    logic [32:0]        r_mag, n_mag;
    logic               r_bad, n_bad;

    logic               r_out_valid;
    logic [2:0]         r_act;
    logic [7:0]         r_cmd;
    logic [31:0]        r_turn;

    logic [7:0]         r_mem [LINE_DEPTH];
    logic [7:0]         r_rd_data;
    logic [LINE_IW-1:0] rd_addr;
    logic               we;

    logic               slot_free;
    logic               emit;
    logic [2:0]         e_act;
    logic [7:0]         e_cmd;
    logic [31:0]        e_turn;

    logic [3:0]         dig;
    logic [36:0]        int_sum;
    logic [36:0]        frac_add;
    logic [36:0]        frac_sum;
    logic [36:0]        mag_ext;

    assign slot_free = !r_out_valid || i_ready;

    assign dig      = r_rd_data[3:0] - CH_0[3:0];
    assign mag_ext  = {4'b0, r_mag};
    assign int_sum  = (mag_ext << 3) + (mag_ext << 1) + (37'(dig) * 37'd1000);

    always_comb begin
        case (r_frac)
            2'd0:    frac_add = 37'(dig) * 37'd100;
            2'd1:    frac_add = 37'(dig) * 37'd10;
            2'd2:    frac_add = 37'(dig);
            default: frac_add = '0;
        endcase
    end

    assign frac_sum = mag_ext + frac_add;

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_count = r_count;
        n_len   = r_len;
        n_idx   = r_idx;
        n_neg   = r_neg;
        n_digit = r_digit;
        n_point = r_point;
        n_frac  = r_frac;
        n_mag   = r_mag;
        n_bad   = r_bad;
        o_pop   = 1'b0;
        we      = 1'b0;
        emit    = 1'b0;
        e_act   = ACT_NONE;
        e_cmd   = '0;
        e_turn  = '0;
        rd_addr = '0;

        case (r_state)
            S_IDLE: begin
                if (!i_empty && slot_free) begin
                    o_pop = 1'b1;
                    emit  = 1'b1;
                    if (!r_mode) begin
                        if (i_item.cls == CLS_TURN) begin
                            n_mode  = 1'b1;
                            n_count = '0;
                        end else begin
                            e_act = ACT_FORWARD;
                            e_cmd = i_item.data;
                        end
                    end else begin
                        case (i_item.cls)
                            CLS_STOP: begin
                                n_mode  = 1'b0;
                                n_count = '0;
                                e_act   = ACT_STOP;
                                e_cmd   = CH_LX;
                            end
                            CLS_GO: begin
                                n_mode  = 1'b0;
                                n_count = '0;
                                e_act   = ACT_FORWARD;
                                e_cmd   = i_item.data;
                            end
                            CLS_ENTER: begin
                                if (r_count == '0) begin
                                    n_mode = 1'b0;
                                    e_act  = ACT_INVALID;
                                end else begin
                                    emit    = 1'b0;
                                    n_state = S_WALK;
                                    n_len   = r_count;
                                    n_idx   = '0;
                                    n_neg   = 1'b0;
                                    n_digit = 1'b0;
                                    n_point = 1'b0;
                                    n_frac  = '0;
                                    n_mag   = '0;
                                    n_bad   = 1'b0;
                                end
                            end
                            CLS_BS: begin
                                if (r_count != '0) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                            default: begin
                                if (r_count >= CNT_MAX) begin
                                    n_mode  = 1'b0;
                                    n_count = '0;
                                    e_act   = ACT_TOO_LONG;
                                end else begin
                                    we      = 1'b1;
                                    n_count = r_count + 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            S_WALK: begin
                rd_addr = r_idx + LINE_IW'(1);
                n_idx   = r_idx + LINE_IW'(1);
                if (r_idx == r_len - 1'b1) begin
                    n_state = S_FIN;
                end
                if (r_idx == '0 && r_rd_data inside {CH_PLUS, CH_MINUS}) begin
                    n_neg = (r_rd_data == CH_MINUS);
                end else if (r_rd_data inside {[CH_0:CH_9]}) begin
                    n_digit = 1'b1;
                    if (!r_point) begin
                        n_mag = (int_sum > MAG_CAP) ? MAG_CAP[32:0] : int_sum[32:0];
                    end else begin
                        n_mag = (frac_sum > MAG_CAP) ? MAG_CAP[32:0] : frac_sum[32:0];
                        if (r_frac != 2'd3) begin
                            n_frac = r_frac + 1'b1;
                        end
                    end
                end else if (r_rd_data == CH_POINT && !r_point) begin
                    n_point = 1'b1;
                end else begin
                    n_bad   = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    n_mode  = 1'b0;
                    n_count = '0;
                    if (r_bad || !r_digit) begin
                        e_act = ACT_INVALID;
                    end else begin
                        e_act = ACT_TURN;
                        if (r_neg) begin
                            e_turn = (r_mag >= NEG_LIM) ? 32'h8000_0000 : (32'd0 - r_mag[31:0]);
                        end else begin
                            e_turn = (r_mag > POS_LIM) ? 32'h7FFF_FFFF : r_mag[31:0];
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_idx   <= n_idx;
        r_neg   <= n_neg;
        r_digit <= n_digit;
        r_point <= n_point;
        r_frac  <= n_frac;
        r_mag   <= n_mag;
        r_bad   <= n_bad;
        if (emit) begin
            r_act  <= e_act;
            r_cmd  <= e_cmd;
            r_turn <= e_turn;
        end
    end

    // line buffer
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_count] <= i_item.data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_valid         = r_out_valid;
    assign o_action        = r_act;
    assign o_command_byte  = r_cmd;
    assign o_turn_millideg = r_turn;

endmodule

>>> src/console_turn_command_parser.sv
// top level of the console turn command parser
//
// input channel: one received console byte per transaction on i_valid / o_ready /
// i_rx_byte. output channel: exactly one result per input byte on o_valid /
// i_ready with o_action, o_command_byte and o_turn_millideg.
// bytes are classified on entry and held in a two-entry queue; the back end
// keeps turn mode, the character count and the line buffer.
// most bytes are handled in the idle state; a result passes through the queue and the output register.
// enter on a non-empty line walks the line buffer one character a cycle through
// its registered read port; the walk sets the worst-case rate.
// results are held in an output register: a stalled receiver holds the result,
// the back end stops once a new result is ready, and the queue fills and drops
// o_ready when both are full.
// reset (i_rst_n low, synchronous) leaves turn mode, empties the line and
// the queue and clears o_valid; line buffer contents are not cleared.
module console_turn_command_parser import ctcp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_action,
    output logic [7:0]         o_command_byte,
    output logic signed [31:0] o_turn_millideg
);

    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    t_item fr_item;
    t_item q_item;
    logic [31:0] turn;

    ctcp_front u_front (
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_full    (full),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_item    (fr_item)
    );

    ctcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (fr_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_item  (q_item)
    );

    ctcp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_item          (q_item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_action        (o_action),
        .o_command_byte  (o_command_byte),
        .o_turn_millideg (turn)
    );

    assign o_turn_millideg = $signed(turn);

endmodule

>>> tb/console_turn_command_parser_test.sv
// self-checking testbench for the console turn command parser
`timescale 1ns / 1ps

module console_turn_command_parser_test;
    import ctcp_pkg::*;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  cmd;
        logic [31:0] turn;
    } t_reply;

    typedef struct packed {
        logic [7:0] rx;
        logic       known;
        t_reply     reply;
    } t_stim_row;

    localparam logic [63:0] MAG_CAP    = 64'h1_0000_0000;
    localparam int          PHASE_SIZE = 580;
    localparam int          HOLD_LEN   = 250;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [2:0]         o_action;
    logic [7:0]         o_command_byte;
    logic signed [31:0] o_turn_millideg;

    console_turn_command_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_action       (o_action),
        .o_command_byte (o_command_byte),
        .o_turn_millideg(o_turn_millideg)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic        turn_mode = 1'b0;
    int unsigned line_len = 0;
    logic [7:0]  line_chars [LINE_DEPTH];

    t_reply replies_due [$];
    int     mismatches = 0;
    int     items_sent = 0;
    int     send_idle_pct = 0;
    int     rcv_idle_pct = 0;
    bit     hold_request = 1'b0;
    int     hold_left = 0;

    t_stim_row directed_rows [25] = '{
        '{8'h00,       1'b1, '{ACT_FORWARD,  8'h00,  32'h0}},
        '{8'hFF,       1'b1, '{ACT_FORWARD,  8'hFF,  32'h0}},
        '{CH_LT,       1'b1, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_BS,       1'b1, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_CR,       1'b1, '{ACT_INVALID,  8'h00,  32'h0}},
        '{CH_UT,       1'b1, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_MINUS,    1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_LF,       1'b1, '{ACT_INVALID,  8'h00,  32'h0}},
        '{CH_LT,       1'b1, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_POINT,    1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_CR,       1'b1, '{ACT_INVALID,  8'h00,  32'h0}},
        '{CH_LT,       1'b1, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_MINUS,    1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_9,        1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_POINT,    1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_0 + 8'd1, 1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_0 + 8'd2, 1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_0 + 8'd3, 1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_0 + 8'd4, 1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_DEL,      1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_CR,       1'b0, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_UT,       1'b1, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_ESC,      1'b1, '{ACT_STOP,     CH_LX,  32'h0}},
        '{CH_LT,       1'b1, '{ACT_NONE,     8'h00,  32'h0}},
        '{CH_LG,       1'b1, '{ACT_FORWARD,  CH_LG,  32'h0}}
    };

    function automatic logic [63:0] sat_mag(input logic [63:0] m);
        return (m > MAG_CAP) ? MAG_CAP : m;
    endfunction

    function automatic logic parse_line(output logic [31:0] bits);
        int unsigned idx;
        int unsigned frac_pos;
        logic        neg;
        logic        digit_seen;
        logic        point_seen;
        logic [63:0] mag;
        logic [63:0] d;
        logic [7:0]  c;
        bits = 32'h0;
        idx = 0;
        frac_pos = 0;
        neg = 1'b0;
        digit_seen = 1'b0;
        point_seen = 1'b0;
        mag = 64'h0;
        if (line_len == 0)
            return 1'b0;
        if (line_chars[0] == CH_PLUS || line_chars[0] == CH_MINUS) begin
            neg = (line_chars[0] == CH_MINUS);
            idx = 1;
        end
        while (idx < line_len) begin
            c = line_chars[idx];
            if (c >= CH_0 && c <= CH_9) begin
                d = 64'(c - CH_0);
                digit_seen = 1'b1;
                if (!point_seen) begin
                    mag = sat_mag(mag * 10 + d * 1000);
                end else begin
                    case (frac_pos)
                        0: mag = mag + d * 100;
                        1: mag = mag + d * 10;
                        2: mag = mag + d;
                        default: ;
                    endcase
                    if (frac_pos < 3)
                        frac_pos++;
                    mag = sat_mag(mag);
                end
            end else if (c == CH_POINT && !point_seen) begin
                point_seen = 1'b1;
            end else begin
                return 1'b0;
            end
            idx++;
        end
        if (!digit_seen)
            return 1'b0;
        if (neg)
            bits = (mag >= 64'h8000_0000) ? 32'h8000_0000 : -mag[31:0];
        else
            bits = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        return 1'b1;
    endfunction

    function automatic t_reply predict_reply(input logic [7:0] b);
        t_reply      r;
        logic [31:0] bits;
        r = '0;
        if (!turn_mode) begin
            if (b == CH_LT || b == CH_UT) begin
                turn_mode = 1'b1;
                line_len = 0;
            end else begin
                r.action = ACT_FORWARD;
                r.cmd = b;
            end
        end else if (b == CH_LX || b == CH_UX || b == CH_SPACE || b == CH_ESC) begin
            turn_mode = 1'b0;
            line_len = 0;
            r.action = ACT_STOP;
            r.cmd = CH_LX;
        end else if (b == CH_LG || b == CH_UG) begin
            turn_mode = 1'b0;
            line_len = 0;
            r.action = ACT_FORWARD;
            r.cmd = b;
        end else if (b == CH_CR || b == CH_LF) begin
            if (parse_line(bits)) begin
                r.action = ACT_TURN;
                r.turn = bits;
            end else begin
                r.action = ACT_INVALID;
            end
            turn_mode = 1'b0;
            line_len = 0;
        end else if (b == CH_BS || b == CH_DEL) begin
            if (line_len > 0)
                line_len--;
        end else if (line_len >= LINE_DEPTH - 1) begin
            turn_mode = 1'b0;
            line_len = 0;
            r.action = ACT_TOO_LONG;
        end else begin
            line_chars[line_len] = b;
            line_len++;
        end
        return r;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic known = 1'b0,
                             input t_reply typed = '0);
        t_reply pred;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        pred = predict_reply(b);
        replies_due.push_back(known ? typed : pred);
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic wait_all_replies();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (replies_due.size() != 0);
    endtask

    task automatic send_text(input string s);
        send_byte(CH_LT);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
        send_byte(CH_CR);
    endtask

    task automatic send_turn_line();
        int   n;
        int   r;
        logic point_done;
        point_done = 1'b0;
        send_byte($urandom_range(1) ? CH_LT : CH_UT);
        case ($urandom_range(9))
            0: n = $urandom_range(15, 18);
            1: n = $urandom_range(10, 14);
            default: n = $urandom_range(0, 9);
        endcase
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (i == 0 && r < 30) begin
                send_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
            end else if (r < 8 && !point_done) begin
                send_byte(CH_POINT);
                point_done = 1'b1;
            end else if (r < 11) begin
                send_byte($urandom_range(1) ? CH_BS : CH_DEL);
            end else if (r < 13) begin
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(CH_0 + 8'($urandom_range(9)));
            end
        end
        r = $urandom_range(99);
        if (r < 75)
            send_byte($urandom_range(1) ? CH_CR : CH_LF);
        else if (r < 83)
            send_byte($urandom_range(1) ? CH_LX : CH_UX);
        else if (r < 88)
            send_byte($urandom_range(1) ? CH_SPACE : CH_ESC);
        else if (r < 94)
            send_byte($urandom_range(1) ? CH_LG : CH_UG);
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct);
        int  goal;
        int  r;
        logic pressed;
        send_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        goal = items_sent + PHASE_SIZE;
        pressed = 1'b0;
        while (items_sent < goal) begin
            if (!pressed && items_sent >= goal - PHASE_SIZE / 2) begin
                pressed = 1'b1;
                hold_request = 1'b1;
                repeat (40) send_byte(8'($urandom_range(255)));
                wait_all_replies();
            end
            r = $urandom_range(99);
            if (r < 15) begin
                send_byte(8'($urandom_range(255)));
            end else if (r < 20) begin
                case ($urandom_range(3))
                    0: send_text("2147483.647");
                    1: send_text("-2147483.648");
                    2: send_text("2147483.648");
                    default: send_text("-0.0009");
                endcase
            end else begin
                send_turn_line();
            end
        end
    endtask

    task automatic check_reply();
        t_reply want;
        if (replies_due.size() == 0) begin
            $error("unexpected transaction: action %0d command_byte %0h turn_millideg %0d",
                   o_action, o_command_byte, o_turn_millideg);
            mismatches++;
        end else begin
            want = replies_due.pop_front();
            if (o_action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, o_action);
                mismatches++;
            end
            if (o_command_byte !== want.cmd) begin
                $error("command_byte: expected %0h, got %0h", want.cmd, o_command_byte);
                mismatches++;
            end
            if (o_turn_millideg !== want.turn) begin
                $error("turn_millideg: expected %0d, got %0d",
                       $signed(want.turn), o_turn_millideg);
                mismatches++;
            end
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready)
                check_reply();
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        #5ms;
        $display("** console_turn_command_parser: FAILED **");
        $finish;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].known, directed_rows[i].reply);
        wait_all_replies();
        run_phase(32, 69);
        run_phase(69, 32);
        run_phase(0, 0);
        wait_all_replies();
        repeat (LINE_DEPTH + 4) @(posedge i_clk);
        if (mismatches == 0)
            $display("** console_turn_command_parser: PASSED **");
        else
            $display("** console_turn_command_parser: FAILED **");
        $finish;
    end

endmodule
